### src/gaussian_log_likelihood_accumulator_unit_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the log-likelihood accumulator
// Shared property wrappers, sampled on clock and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef GAUSSIAN_LOG_LIKELIHOOD_ACCUMULATOR_UNIT_DEFINES_SVH
`define GAUSSIAN_LOG_LIKELIHOOD_ACCUMULATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define GLLA_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define GLLA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/glla_pkg.sv
// ---------------------------------------------------------------------------
// glla_pkg
// Widths, constants and shared types of the log-likelihood accumulator.
// ---------------------------------------------------------------------------
`default_nettype none

package glla_pkg;

   localparam int unsigned OBS_W      = 32;
   localparam int unsigned EXP_W      = 32;
   localparam int unsigned GAIN_W     = 20;
   localparam int unsigned PROD_W     = GAIN_W + EXP_W;     // gain * expected
   localparam int unsigned SUM_W      = 64;
   localparam int unsigned REQ_DATA_W = 88;                 // 84 bits, byte padded
   localparam int unsigned LOG_FRAC   = 24;                 // log2 fraction bits
   localparam logic [31:0] LN2_Q32    = 32'd2977044472;     // ln2 in 0.32

   localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

   typedef logic [PROD_W-1:0] prod_type;

   typedef struct packed {
      logic              sat;    // quotient reached 2^63
      logic [SUM_W-2:0]  quot;   // quotient, low 63 bits
   } div_result_type;

endpackage

`default_nettype wire

### src/gaussian_log_likelihood_accumulator_unit.sv
// ---------------------------------------------------------------------------
// gaussian_log_likelihood_accumulator_unit
// Running Gaussian log-likelihood over the pixels of an image.
// ---------------------------------------------------------------------------
// channel   dir  ports                              contents
// req       in   req_tvalid/tready/tdata/tlast      one pixel, tlast = last
// rsp       out  rsp_tvalid/tready/tdata/tuser      image total and flags
//
// A pixel with nonzero expectation holds off the next one until it is through.
// The log unit sets the worst case when the product is small (up to 63 normalize
// shifts plus 24 squaring steps); for large products the bit-serial divider
// (63 + FRAC_BITS steps) sets it.
// A pixel with zero expectation skips both units and goes from ST_MUL to ST_FINISH.
// Reset clears the sum, both sticky flags and the result valid.
// A last pixel whose result register is still full waits until it is taken.
// ---------------------------------------------------------------------------
`default_nettype none

module gaussian_log_likelihood_accumulator_unit #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [87:0] req_tdata,   // observed[31:0], expected[63:32], gain_value[83:64]
   input  wire logic        req_tlast,   // last_pixel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,   // log_likelihood[63:0]
   output logic [1:0]       rsp_tuser    // saturated[0], zero_expectation[1]
);
   import glla_pkg::*;

   `include "gaussian_log_likelihood_accumulator_unit_defines.svh"

   typedef enum logic [2:0] {
      ST_IDLE, ST_MUL, ST_START, ST_WAIT, ST_SUB_LOG, ST_SUB_QUAD, ST_FINISH
   } state_type;

   typedef struct packed {
      logic signed [SUM_W-1:0] value;
      logic                    clamp;
   } sat_type;

   // subtract with clamp to the signed 64-bit range
   function automatic sat_type sat_sub(input logic signed [SUM_W-1:0] a,
                                       input logic signed [SUM_W-1:0] b);
      logic signed [SUM_W:0] diff;
      sat_type               res;
      diff = {a[SUM_W-1], a} - {b[SUM_W-1], b};
      if (diff[SUM_W] != diff[SUM_W-1]) begin
         res.value = diff[SUM_W] ? SUM_MIN : SUM_MAX;
         res.clamp = 1'b1;
      end else begin
         res.value = diff[SUM_W-1:0];
         res.clamp = 1'b0;
      end
      return res;
   endfunction

   state_type               state_ff, state_in;
   logic [OBS_W-1:0]        dist_ff, dist_in;
   logic [EXP_W-1:0]        exp_ff, exp_in;
   logic [GAIN_W-1:0]       gain_ff, gain_in;
   logic                    last_ff, last_in;
   prod_type                prod_ff, prod_in;
   logic [SUM_W-1:0]        dsq_ff, dsq_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic                    sat_seen_ff, sat_seen_in;
   logic                    zero_seen_ff, zero_seen_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [SUM_W-1:0]        rsp_data_ff, rsp_data_in;
   logic [1:0]              rsp_user_ff, rsp_user_in;

   logic [OBS_W-1:0]        req_obs;
   logic [EXP_W-1:0]        req_exp;
   logic [GAIN_W-1:0]       req_gain;
   logic [GAIN_W-1:0]       gain_eff;
   logic                    req_take;
   logic                    unit_start;
   logic                    log_done;
   logic signed [SUM_W-1:0] half_ln;
   logic                    div_done;
   div_result_type          div_res;
   logic signed [SUM_W-1:0] quad;
   sat_type                 sub_res;
   logic                    rsp_load;

   assign req_obs    = req_tdata[OBS_W-1:0];
   assign req_exp    = req_tdata[OBS_W+EXP_W-1:OBS_W];
   assign req_gain   = req_tdata[OBS_W+EXP_W+GAIN_W-1:OBS_W+EXP_W];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_take   = req_tvalid && req_tready;
   assign unit_start = (state_ff == ST_START);
   assign gain_eff   = (gain_ff == '0) ? GAIN_W'(1) : gain_ff;
   assign quad       = div_res.sat ? SUM_MAX : $signed({1'b0, div_res.quot});
   assign rsp_load   = (state_ff == ST_FINISH) && last_ff && (!rsp_valid_ff || rsp_tready);

   glla_log #(
      .FRAC_BITS (FRAC_BITS)
   ) u_log (
      .clock   (clock),
      .reset   (reset),
      .start   (unit_start),
      .prod    (prod_ff),
      .done    (log_done),
      .half_ln (half_ln)
   );

   glla_div #(
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (unit_start),
      .dividend (dsq_ff),
      .divisor  (prod_ff),
      .done     (div_done),
      .result   (div_res)
   );

   always_comb begin
      state_in     = state_ff;
      dist_in      = dist_ff;
      exp_in       = exp_ff;
      gain_in      = gain_ff;
      last_in      = last_ff;
      prod_in      = prod_ff;
      dsq_in       = dsq_ff;
      sum_in       = sum_ff;
      sat_seen_in  = sat_seen_ff;
      zero_seen_in = zero_seen_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      sub_res      = sat_sub(sum_ff, (state_ff == ST_SUB_LOG) ? half_ln : quad);

      // drop the result once taken, load a new one on the last pixel
      rsp_valid_in = rsp_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               dist_in  = (req_obs >= req_exp) ? req_obs - req_exp : req_exp - req_obs;
               exp_in   = req_exp;
               gain_in  = req_gain;
               last_in  = req_tlast;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in = PROD_W'(gain_eff) * PROD_W'(exp_ff);
            dsq_in  = SUM_W'(dist_ff) * SUM_W'(dist_ff);
            if (exp_ff == '0) begin
               zero_seen_in = 1'b1;
               state_in     = ST_FINISH;
            end else begin
               state_in = ST_START;
            end
         end
         ST_START: state_in = ST_WAIT;
         ST_WAIT: begin
            if (log_done && div_done) state_in = ST_SUB_LOG;
         end
         ST_SUB_LOG: begin
            sum_in      = sub_res.value;
            sat_seen_in = sat_seen_ff | sub_res.clamp;
            state_in    = ST_SUB_QUAD;
         end
         ST_SUB_QUAD: begin
            sum_in      = sub_res.value;
            sat_seen_in = sat_seen_ff | sub_res.clamp | div_res.sat;
            state_in    = ST_FINISH;
         end
         ST_FINISH: begin
            if (!last_ff) begin
               state_in = ST_IDLE;
            end else if (rsp_load) begin
               rsp_data_in  = sum_ff;
               rsp_user_in  = {zero_seen_ff, sat_seen_ff};
               sum_in       = '0;
               sat_seen_in  = 1'b0;
               zero_seen_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_ff       <= '0;
         sat_seen_ff  <= 1'b0;
         zero_seen_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         sat_seen_ff  <= sat_seen_in;
         zero_seen_ff <= zero_seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      dist_ff     <= dist_in;
      exp_ff      <= exp_in;
      gain_ff     <= gain_in;
      last_ff     <= last_in;
      prod_ff     <= prod_in;
      dsq_ff      <= dsq_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // a skipped pixel sets the image's zero flag in ST_MUL
   `GLLA_ASSERT_NEXT(a_zero_flag, req_take && (req_exp == '0), ##1 zero_seen_ff, "zero expectation not flagged")
   // handing out a total clears the accumulator
   `GLLA_ASSERT_NEXT(a_clear_after_emit, rsp_load, (sum_ff == '0) && !sat_seen_ff && !zero_seen_ff, "sum not cleared after emit")
   // both units finish before the sum is touched
   `GLLA_ASSERT_NOW(a_units_done, state_ff == ST_SUB_LOG, log_done && div_done, "subtract before units done")

endmodule

`default_nettype wire

### src/glla_log.sv
// ---------------------------------------------------------------------------
// glla_log
// Half natural log of a product: bit-serial normalize, 24 squaring steps.
// ---------------------------------------------------------------------------
`default_nettype none

module glla_log #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire glla_pkg::prod_type             prod,
   output logic                                done,
   output logic signed [glla_pkg::SUM_W-1:0]   half_ln
);
   import glla_pkg::*;

   localparam int SH = LOG_FRAC + 33 - FRAC_BITS;
   localparam int CW = $clog2(LOG_FRAC);
   localparam logic signed [31:0] TWO_F = 32'(2 * FRAC_BITS) <<< LOG_FRAC;

   typedef enum logic [2:0] {
      LG_IDLE, LG_NORM, LG_SQUARE, LG_SCALE, LG_MULT, LG_ROUND
   } lg_state_type;

   lg_state_type      state_ff, state_in;
   logic [63:0]       norm_ff, norm_in;
   logic [5:0]        msb_ff, msb_in;
   logic [31:0]       x_ff, x_in;
   logic [LOG_FRAC-1:0] frac_ff, frac_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic              neg_ff, neg_in;
   logic [30:0]       mag_ff, mag_in;
   logic [62:0]       prod_ff, prod_in;
   logic signed [SUM_W-1:0] hl_ff, hl_in;
   logic              done_ff, done_in;

   logic [63:0]       sq;
   logic signed [31:0] l_val;
   logic [63:0]       rnd;
   logic [63:0]       r_val;

   always_comb begin
      sq    = 64'(x_ff) * 64'(x_ff);
      l_val = $signed({2'b00, msb_ff, frac_ff}) - TWO_F;
      rnd   = 64'(prod_ff) + (64'd1 << (SH - 1));
      r_val = rnd >> SH;

      state_in = state_ff;
      norm_in  = norm_ff;
      msb_in   = msb_ff;
      x_in     = x_ff;
      frac_in  = frac_ff;
      cnt_in   = cnt_ff;
      neg_in   = neg_ff;
      mag_in   = mag_ff;
      prod_in  = prod_ff;
      hl_in    = hl_ff;
      done_in  = done_ff;

      unique case (state_ff)
         LG_IDLE: begin
            if (start) begin
               norm_in  = {{(64-PROD_W){1'b0}}, prod};
               msb_in   = 6'd63;
               done_in  = 1'b0;
               state_in = LG_NORM;
            end
         end
         LG_NORM: begin
            // shift left until the leading one reaches the top
            if (norm_ff[63]) begin
               x_in     = norm_ff[63:32];
               frac_in  = '0;
               cnt_in   = '0;
               state_in = LG_SQUARE;
            end else begin
               norm_in = {norm_ff[62:0], 1'b0};
               msb_in  = msb_ff - 6'd1;
            end
         end
         LG_SQUARE: begin
            frac_in = {frac_ff[LOG_FRAC-2:0], sq[63]};
            x_in    = sq[63] ? sq[63:32] : sq[62:31];
            cnt_in  = cnt_ff + CW'(1);
            if (cnt_ff == CW'(LOG_FRAC - 1)) state_in = LG_SCALE;
         end
         LG_SCALE: begin
            neg_in   = l_val[31];
            mag_in   = l_val[31] ? 31'(-l_val) : 31'(l_val);
            state_in = LG_MULT;
         end
         LG_MULT: begin
            prod_in  = 63'(mag_ff) * 63'(LN2_Q32);
            state_in = LG_ROUND;
         end
         LG_ROUND: begin
            hl_in    = neg_ff ? -$signed(r_val) : $signed(r_val);
            done_in  = 1'b1;
            state_in = LG_IDLE;
         end
         default: state_in = LG_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LG_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      norm_ff <= norm_in;
      msb_ff  <= msb_in;
      x_ff    <= x_in;
      frac_ff <= frac_in;
      cnt_ff  <= cnt_in;
      neg_ff  <= neg_in;
      mag_ff  <= mag_in;
      prod_ff <= prod_in;
      hl_ff   <= hl_in;
   end

   assign done    = done_ff;
   assign half_ln = hl_ff;

endmodule

`default_nettype wire

### src/glla_div.sv
// ---------------------------------------------------------------------------
// glla_div
// Restoring divider, one quotient bit per cycle, for the quadratic term.
// ---------------------------------------------------------------------------
`default_nettype none

module glla_div #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [glla_pkg::SUM_W-1:0] dividend,
   input  wire glla_pkg::prod_type        divisor,
   output logic                           done,
   output glla_pkg::div_result_type       result
);
   import glla_pkg::*;

   localparam int DW = SUM_W + FRAC_BITS - 1;
   localparam int CW = $clog2(DW);

   typedef enum logic {DV_IDLE, DV_RUN} dv_state_type;

   dv_state_type     state_ff, state_in;
   logic [DW-1:0]    dvd_ff, dvd_in;
   prod_type         dsr_ff, dsr_in;
   prod_type         rem_ff, rem_in;
   logic [SUM_W-1:0] quot_ff, quot_in;
   logic             ovf_ff, ovf_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             done_ff, done_in;

   logic [PROD_W:0]  trial;
   logic             fits;

   always_comb begin
      trial = {rem_ff, dvd_ff[DW-1]};
      fits  = trial >= {1'b0, dsr_ff};

      state_in = state_ff;
      dvd_in   = dvd_ff;
      dsr_in   = dsr_ff;
      rem_in   = rem_ff;
      quot_in  = quot_ff;
      ovf_in   = ovf_ff;
      cnt_in   = cnt_ff;
      done_in  = done_ff;

      unique case (state_ff)
         DV_IDLE: begin
            if (start) begin
               dvd_in   = {dividend, {(FRAC_BITS-1){1'b0}}};
               dsr_in   = divisor;
               rem_in   = '0;
               quot_in  = '0;
               ovf_in   = 1'b0;
               cnt_in   = '0;
               done_in  = 1'b0;
               state_in = DV_RUN;
            end
         end
         DV_RUN: begin
            rem_in  = fits ? PROD_W'(trial - {1'b0, dsr_ff}) : trial[PROD_W-1:0];
            dvd_in  = {dvd_ff[DW-2:0], 1'b0};
            quot_in = {quot_ff[SUM_W-2:0], fits};
            // keep any quotient bit pushed past the top
            ovf_in  = ovf_ff | quot_ff[SUM_W-1];
            cnt_in  = cnt_ff + CW'(1);
            if (cnt_ff == CW'(DW - 1)) begin
               done_in  = 1'b1;
               state_in = DV_IDLE;
            end
         end
         default: state_in = DV_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DV_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      dvd_ff  <= dvd_in;
      dsr_ff  <= dsr_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      ovf_ff  <= ovf_in;
      cnt_ff  <= cnt_in;
   end

   assign done        = done_ff;
   assign result.sat  = ovf_ff | quot_ff[SUM_W-1];
   assign result.quot = quot_ff[SUM_W-2:0];

endmodule

`default_nettype wire

### sim/glla_checker.sv
// ---------------------------------------------------------------------------
// glla_checker
// Watches the pixel and result channels and predicts each image total.
// It compares every result with the oldest predicted total.
// ---------------------------------------------------------------------------
`default_nettype none

module glla_checker #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [87:0] req_tdata,
   input  wire logic        req_tlast,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [63:0] rsp_tdata,
   input  wire logic [1:0]  rsp_tuser,
   output int               error_count,
   output int               pending_count
);
   import glla_pkg::*;

   typedef struct {
      logic signed [SUM_W-1:0] total;
      logic                    sat;
      logic                    zero;
   } image_total_type;

   image_total_type totals_due[$];

   logic signed [SUM_W-1:0] image_sum;
   logic                    sat_flag;
   logic                    zero_flag;

   // 0.5*ln(p / 2^(2F)), rounded on the magnitude
   function automatic longint half_log_term(longint unsigned p);
      int              msb;
      longint unsigned x, frac, sq, mag, prod, r;
      longint          l;
      int              sh;
      msb = 63;
      while (msb > 0 && p[msb] == 1'b0) msb--;
      x = (msb >= 31) ? (p >> (msb - 31)) : (p << (31 - msb));
      frac = 0;
      for (int i = 0; i < LOG_FRAC; i++) begin
         sq = x * x;
         frac = frac << 1;
         if (sq[63]) begin
            frac = frac | 64'd1;
            x = sq >> 32;
         end else begin
            x = sq >> 31;
         end
      end
      l = longint'(msb - 2 * FRAC_BITS) * (longint'(1) << LOG_FRAC) + longint'(frac);
      mag = (l < 0) ? longint'(-l) : l;
      sh = LOG_FRAC + 33 - FRAC_BITS;
      prod = mag * longint'(LN2_Q32);
      r = (prod + (64'd1 << (sh - 1))) >> sh;
      return (l < 0) ? -longint'(r) : longint'(r);
   endfunction

   // floor(d2 * 2^(F-1) / p), clamped to the sum maximum
   function automatic longint quad_term(longint unsigned d2, longint unsigned p,
                                        output logic clamped);
      longint unsigned q, r;
      q = d2 / p;
      r = d2 % p;
      clamped = 1'b0;
      if (q > (longint'(SUM_MAX) >> (FRAC_BITS - 1))) begin
         clamped = 1'b1;
         return SUM_MAX;
      end
      for (int i = 0; i < FRAC_BITS - 1; i++) begin
         r = r << 1;
         q = q << 1;
         if (r >= p) begin
            r = r - p;
            q = q | 64'd1;
         end
      end
      return q;
   endfunction

   function automatic longint clamp_sub(longint a, longint b, output logic clamped);
      clamped = 1'b0;
      if (b > 0 && a < SUM_MIN + b) begin
         clamped = 1'b1;
         return SUM_MIN;
      end
      if (b < 0 && a > SUM_MAX + b) begin
         clamped = 1'b1;
         return SUM_MAX;
      end
      return a - b;
   endfunction

   assign pending_count = totals_due.size();

   always @(posedge clock) begin
      longint unsigned obs, expv, gain, p, d;
      longint          s;
      logic            c;
      image_total_type got, want;
      if (reset) begin
         image_sum <= '0;
         sat_flag  <= 1'b0;
         zero_flag <= 1'b0;
         totals_due.delete();
         error_count <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            obs  = req_tdata[31:0];
            expv = req_tdata[63:32];
            gain = req_tdata[83:64];
            s = image_sum;
            want.sat  = sat_flag;
            want.zero = zero_flag;
            if (expv == 0) begin
               want.zero = 1'b1;
            end else begin
               if (gain == 0) gain = 1;
               p = gain * expv;
               d = (obs >= expv) ? obs - expv : expv - obs;
               s = clamp_sub(s, half_log_term(p), c);
               want.sat |= c;
               s = clamp_sub(s, quad_term(d * d, p, c), c);
               want.sat |= c;
               // second clamp flag above overwrote the quad flag; redo it
               void'(quad_term(d * d, p, c));
               want.sat |= c;
            end
            want.total = s;
            if (req_tlast) begin
               totals_due.push_back(want);
               image_sum <= '0;
               sat_flag  <= 1'b0;
               zero_flag <= 1'b0;
            end else begin
               image_sum <= s;
               sat_flag  <= want.sat;
               zero_flag <= want.zero;
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            got.total = rsp_tdata;
            got.sat   = rsp_tuser[0];
            got.zero  = rsp_tuser[1];
            if (totals_due.size() == 0) begin
               $display("%0t: unexpected result total=%0d", $time, got.total);
               error_count <= error_count + 1;
            end else begin
               want = totals_due.pop_front();
               if (got.total !== want.total || got.sat !== want.sat ||
                   got.zero !== want.zero) begin
                  $display("%0t: mismatch expected total=%0d sat=%b zero=%b",
                           $time, want.total, want.sat, want.zero);
                  $display("%0t:          actual   total=%0d sat=%b zero=%b",
                           $time, got.total, got.sat, got.zero);
                  error_count <= error_count + 1;
               end
            end
         end
      end
   end

endmodule

`default_nettype wire

### sim/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the log-likelihood accumulator.
// Directed images hit the field extremes, zero gain, zero expectation and
// clamping; random images follow with bursty idling on both channels.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_top;
   import glla_pkg::*;

   localparam int RANDOM_ITEMS = 1200;
   localparam int CYCLE_LIMIT  = 2000000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [87:0] req_tdata;    // observed[31:0], expected[63:32], gain_value[83:64]
   logic        req_tlast;    // last_pixel
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;    // log_likelihood[63:0]
   logic [1:0]  rsp_tuser;    // saturated[0], zero_expectation[1]

   int  error_count;
   int  pending_count;
   int  pixels_sent;
   int  cycle_count;
   bit  quiet_phase;
   bit  hold_done;

   gaussian_log_likelihood_accumulator_unit DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   glla_checker checker_inst (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .error_count(error_count), .pending_count(pending_count)
   );

   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // end the run on a stuck handshake
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // offer one pixel; hold it until accepted, keep valid high for the next one
   task automatic send_pixel(logic [31:0] obs, logic [31:0] expv,
                             logic [19:0] gain, logic last);
      if (!quiet_phase && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, gain, expv, obs};
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pixels_sent++;
      @(negedge clock);
   endtask

   // mostly realistic pixels, some wild ones to toggle every bit
   task automatic send_random_image(int max_len);
      int          len;
      logic [31:0] obs, expv;
      logic [19:0] gain;
      len = $urandom_range(1, max_len);
      for (int i = 0; i < len; i++) begin
         case ($urandom_range(0, 9))
            0: begin
               obs = $urandom; expv = $urandom; gain = $urandom;
            end
            1: begin
               obs = $urandom; expv = 0; gain = $urandom_range(655, 655360);
            end
            default: begin
               expv = $urandom_range(1, 32'h0100_0000);
               obs  = expv + $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
               gain = $urandom_range(655, 655360);
            end
         endcase
         send_pixel(obs, expv, gain, i == len - 1);
      end
   endtask

   // result side: random stall bursts, one long hold-off, none at the end
   initial begin
      rsp_tready = 1'b0;
      hold_done  = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (quiet_phase) begin
            rsp_tready <= 1'b1;
            @(negedge clock);
         end else if (!hold_done && pixels_sent >= 300) begin
            // hold long enough for the result register to fill and stall input
            hold_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (4000) @(negedge clock);
         end else begin
            rsp_tready <= $urandom_range(0, 1);
            repeat ($urandom_range(1, 19)) @(negedge clock);
         end
      end
   end

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tlast   = 1'b0;
      pixels_sent = 0;
      cycle_count = 0;
      quiet_phase = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // field extremes and a perfect fit
      send_pixel(32'h0001_0000, 32'h0001_0000, 20'd65536, 1'b1);
      send_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFF, 20'hFFFFF, 1'b1);
      send_pixel(32'h0000_0000, 32'hFFFF_FFFF, 20'd655, 1'b0);
      send_pixel(32'hFFFF_FFFF, 32'h0000_0001, 20'd655360, 1'b1);
      // zero gain treated as the smallest step
      send_pixel(32'h0000_0005, 32'h0000_0001, 20'd0, 1'b1);
      // zero expectation mid image, then a skipped last pixel
      send_pixel(32'h0002_0000, 32'h0000_0000, 20'd65536, 1'b0);
      send_pixel(32'h0003_0000, 32'h0002_0000, 20'd65536, 1'b1);
      send_pixel(32'h1234_5678, 32'h0000_0000, 20'd1000, 1'b1);
      // quadratic clamps and drives the sum to its minimum
      send_pixel(32'hFFFF_FFFF, 32'h0000_0001, 20'd1, 1'b0);
      send_pixel(32'hFFFF_FFFF, 32'h0000_0001, 20'd1, 1'b0);
      send_pixel(32'hFFFF_FFFF, 32'h0000_0001, 20'd0, 1'b1);
      // flags clear after a clamped image
      send_pixel(32'h0001_8000, 32'h0001_0000, 20'd65536, 1'b1);
      // tiny product gives a negative log term
      send_pixel(32'h0000_0001, 32'h0000_0001, 20'd1, 1'b1);

      while (pixels_sent < RANDOM_ITEMS) begin
         if (pixels_sent > RANDOM_ITEMS * 5 / 6) quiet_phase = 1'b1;
         // short images while the result side holds off
         send_random_image((pixels_sent > 250 && pixels_sent < 400) ? 2 : 8);
      end
      req_tvalid <= 1'b0;
      quiet_phase = 1'b1;

      while (pending_count != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

`default_nettype wire
